### rtl/core/socc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// socc_pkg: shared types and helpers for the segment checksum checker
// Beat layouts for both channels, item kind codes and the end-around add.
// ----------------------------------------------------------------------------
package socc_pkg;

    localparam int SumWidth = 16;

    // Item kinds carried in cmd
    localparam logic CMD_HEADER = 1'b0;
    localparam logic CMD_DATA   = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [31:0] conn_id;
        logic [31:0] src_ip;
        logic [15:0] src_port;
        logic [15:0] hdr_flags;
        logic [15:0] data_len;
        logic [15:0] rx_checksum;
        logic [7:0]  data_byte;
    } item_t;

    typedef struct packed {
        logic [15:0] computed_sum;
        logic        corrupt;
    } result_t;

    // One's-complement add with end-around carry
    function automatic logic [SumWidth-1:0] oc_add(
        input logic [SumWidth-1:0] a,
        input logic [SumWidth-1:0] b
    );
        logic [SumWidth:0] s;
        begin
            s      = {1'b0, a} + {1'b0, b};
            oc_add = s[SumWidth-1:0] + {{(SumWidth-1){1'b0}}, s[SumWidth]};
        end
    endfunction

endpackage

### rtl/core/segment_ones_complement_checker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_ones_complement_checker_top: segment checksum checker
// Path: the beat that completes a segment passes the input register, then the
//   sum update into the result register, which drives the result.
// Throughput: one beat per cycle when results drain; sum updates once per beat.
// Reset: asynchronous, active low; clears the segment state and both valid
//   flags, leaving the block idle and outside any segment.
// ----------------------------------------------------------------------------
module segment_ones_complement_checker_top
    import socc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    // Input register
    logic        in_valid_reg;
    item_t       in_item_reg;

    // Segment state
    logic [15:0] running_sum_reg, running_sum_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [7:0]  held_low_byte_reg, held_low_byte_next;
    logic        odd_phase_reg, odd_phase_next;
    logic        in_segment_reg, in_segment_next;
    logic [15:0] expected_sum_reg, expected_sum_next;

    // Result register
    logic        result_valid_reg;
    result_t     result_reg;

    logic        advance;
    logic        emit;
    logic [15:0] final_sum;
    logic [15:0] final_expected;
    logic [18:0] hdr_raw;
    logic [16:0] hdr_fold1;
    logic [15:0] hdr_sum;
    logic [15:0] left_dec;
    logic [15:0] pair_word;

    // Stage two moves whenever the result slot is free or being drained
    assign advance    = !result_valid_reg || result_ready;
    assign item_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            in_item_reg <= item;
        end
    end

    // Header sum: wide add of all seven words, then fold the carries back twice
    always_comb
    begin
        hdr_raw   = {3'b0, in_item_reg.conn_id[15:0]}
                  + {3'b0, in_item_reg.conn_id[31:16]}
                  + {3'b0, in_item_reg.src_ip[15:0]}
                  + {3'b0, in_item_reg.src_ip[31:16]}
                  + {3'b0, in_item_reg.src_port}
                  + {3'b0, in_item_reg.hdr_flags}
                  + {3'b0, in_item_reg.data_len};
        hdr_fold1 = {1'b0, hdr_raw[15:0]} + {14'b0, hdr_raw[18:16]};
        hdr_sum   = hdr_fold1[15:0] + {15'b0, hdr_fold1[16]};
    end

    always_comb
    begin
        running_sum_next   = running_sum_reg;
        bytes_left_next    = bytes_left_reg;
        held_low_byte_next = held_low_byte_reg;
        odd_phase_next     = odd_phase_reg;
        in_segment_next    = in_segment_reg;
        expected_sum_next  = expected_sum_reg;
        emit               = 1'b0;
        left_dec           = bytes_left_reg - 16'd1;
        pair_word          = {in_item_reg.data_byte, held_low_byte_reg};

        if (in_valid_reg && advance)
        begin
            if (in_item_reg.cmd == CMD_HEADER)
            begin
                running_sum_next   = hdr_sum;
                bytes_left_next    = in_item_reg.data_len;
                expected_sum_next  = in_item_reg.rx_checksum;
                held_low_byte_next = 8'd0;
                odd_phase_next     = 1'b0;
                in_segment_next    = (in_item_reg.data_len != 16'd0);
                emit               = (in_item_reg.data_len == 16'd0);
            end
            else if (in_segment_reg)
            begin
                bytes_left_next = left_dec;
                if (!odd_phase_reg)
                begin
                    held_low_byte_next = in_item_reg.data_byte;
                    odd_phase_next     = 1'b1;
                    if (left_dec == 16'd0)
                    begin
                        // odd tail: add the byte with a zero high half
                        running_sum_next = oc_add(running_sum_reg,
                                                  {8'd0, in_item_reg.data_byte});
                        emit             = 1'b1;
                    end
                end
                else
                begin
                    running_sum_next   = oc_add(running_sum_reg, pair_word);
                    held_low_byte_next = 8'd0;
                    odd_phase_next     = 1'b0;
                    emit               = (left_dec == 16'd0);
                end
            end

            if (emit)
            begin
                in_segment_next    = 1'b0;
                odd_phase_next     = 1'b0;
                held_low_byte_next = 8'd0;
                bytes_left_next    = 16'd0;
            end
        end

        final_sum      = ~running_sum_next;
        final_expected = expected_sum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_sum_reg   <= '0;
            bytes_left_reg    <= '0;
            held_low_byte_reg <= '0;
            odd_phase_reg     <= 1'b0;
            in_segment_reg    <= 1'b0;
            expected_sum_reg  <= '0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            running_sum_reg   <= running_sum_next;
            bytes_left_reg    <= bytes_left_next;
            held_low_byte_reg <= held_low_byte_next;
            odd_phase_reg     <= odd_phase_next;
            in_segment_reg    <= in_segment_next;
            expected_sum_reg  <= expected_sum_next;
            if (advance)
            begin
                result_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            result_reg.computed_sum <= final_sum;
            result_reg.corrupt      <= (final_sum != final_expected);
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    // A held low byte only exists inside a segment
    assert property (@(posedge clk) disable iff (!rst_n)
        odd_phase_reg |-> in_segment_reg)
    else $error("odd phase set outside a segment");

    // Inside a segment at least one byte is still owed; outside, none
    assert property (@(posedge clk) disable iff (!rst_n)
        in_segment_reg == (bytes_left_reg != 16'd0))
    else $error("byte count disagrees with segment flag");

    // A new result only follows a beat taken from the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(in_valid_reg))
    else $error("result raised without an input beat");

    // A stalled result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !result_ready) |=> $stable(result_reg))
    else $error("pending result overwritten");
`endif

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: segment checksum checker
// Drives header and payload beats through the valid/ready input channel,
// keeps a running prediction of every segment's inverted one's-complement
// sum and corrupt flag, and compares each result beat in order. Covers empty
// and odd-length segments, stray bytes, abandoned segments, bursty input and
// a stalled result channel.
// ----------------------------------------------------------------------------
module testbench;
    import socc_pkg::*;

    localparam int RandomItems  = 450;
    localparam int HoldCycles   = 300;
    localparam int DrainCycles  = 8;
    localparam int CycleLimit   = 300000;

    typedef logic [7:0] bytes_t [$];

    typedef enum int {SUM_GOOD, SUM_RANDOM, SUM_FLIPPED, SUM_AS_GIVEN} sum_mode_t;
    typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_TOGGLE} ready_mode_t;

    class checksum_tracker;
        logic [15:0] run_sum;
        logic [15:0] bytes_left;
        logic [15:0] rx_sum;
        logic [7:0]  held_byte;
        logic        odd_phase;
        logic        in_segment;
        result_t     expected_results[$];
        int          errors;
        int          checked;

        function new();
            run_sum    = '0;
            bytes_left = '0;
            rx_sum     = '0;
            held_byte  = '0;
            odd_phase  = 1'b0;
            in_segment = 1'b0;
            errors     = 0;
            checked    = 0;
        endfunction

        static function logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
            logic [16:0] wide;
            wide = {1'b0, a} + {1'b0, b};
            return wide[15:0] + {15'd0, wide[16]};
        endfunction

        function void close_segment();
            result_t r;
            r.computed_sum = ~run_sum;
            r.corrupt      = (r.computed_sum != rx_sum);
            expected_results.push_back(r);
            in_segment = 1'b0;
            odd_phase  = 1'b0;
            held_byte  = '0;
            bytes_left = '0;
        endfunction

        function void note_item(input item_t it);
            logic [15:0] s;
            if (it.cmd == CMD_HEADER)
            begin
                s = '0;
                s = ones_add(s, it.conn_id[15:0]);
                s = ones_add(s, it.conn_id[31:16]);
                s = ones_add(s, it.src_ip[15:0]);
                s = ones_add(s, it.src_ip[31:16]);
                s = ones_add(s, it.src_port);
                s = ones_add(s, it.hdr_flags);
                s = ones_add(s, it.data_len);
                run_sum    = s;
                bytes_left = it.data_len;
                rx_sum     = it.rx_checksum;
                held_byte  = '0;
                odd_phase  = 1'b0;
                in_segment = 1'b1;
                if (bytes_left == 16'd0)
                    close_segment();
            end
            else if (in_segment)
            begin
                bytes_left = bytes_left - 16'd1;
                if (!odd_phase)
                begin
                    held_byte = it.data_byte;
                    odd_phase = 1'b1;
                    if (bytes_left == 16'd0)
                    begin
                        // odd length: last byte pads with a zero high half
                        run_sum = ones_add(run_sum, {8'h00, held_byte});
                        close_segment();
                    end
                end
                else
                begin
                    run_sum   = ones_add(run_sum, {it.data_byte, held_byte});
                    odd_phase = 1'b0;
                    held_byte = '0;
                    if (bytes_left == 16'd0)
                        close_segment();
                end
            end
        endfunction

        function void check_result(input result_t got);
            result_t want;
            checked++;
            if (expected_results.size() == 0)
            begin
                $error("result beat with nothing pending: computed_sum=%h corrupt=%b",
                       got.computed_sum, got.corrupt);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (got.computed_sum !== want.computed_sum)
            begin
                $error("computed_sum: expected %h, actual %h", want.computed_sum,
                       got.computed_sum);
                errors++;
            end
            if (got.corrupt !== want.corrupt)
            begin
                $error("corrupt: expected %b, actual %b", want.corrupt, got.corrupt);
                errors++;
            end
        endfunction
    endclass

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_ready;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    checksum_tracker tracker;
    int burst_left = 0;
    int items_sent = 0;
    int cycles     = 0;

    segment_ones_complement_checker_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Checksum of a complete segment, worked out on a scratch tracker
    function automatic logic [15:0] true_checksum(input item_t hdr, input bytes_t payload);
        checksum_tracker calc;
        item_t           d;
        calc = new();
        d    = '0;
        hdr.cmd = CMD_HEADER;
        calc.note_item(hdr);
        d.cmd = CMD_DATA;
        foreach (payload[i])
        begin
            d.data_byte = payload[i];
            calc.note_item(d);
        end
        return calc.expected_results[0].computed_sum;
    endfunction

    function automatic item_t random_header();
        item_t h;
        h.cmd         = CMD_HEADER;
        h.conn_id     = $urandom;
        h.src_ip      = $urandom;
        h.src_port    = 16'($urandom);
        h.hdr_flags   = 16'($urandom);
        h.data_len    = 16'($urandom);
        h.rx_checksum = 16'($urandom);
        h.data_byte   = 8'($urandom);
        return h;
    endfunction

    task automatic put_beat(input item_t beat);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        item_valid <= 1'b1;
        item       <= beat;
        do @(posedge clk); while (!item_ready);
    endtask

    task automatic put_data(input logic [7:0] b);
        item_t d;
        d           = random_header();
        d.cmd       = CMD_DATA;
        d.data_byte = b;
        put_beat(d);
    endtask

    task automatic put_segment(input item_t hdr, input bytes_t payload,
                               input sum_mode_t mode);
        logic [15:0] good;
        hdr.cmd = CMD_HEADER;
        if (mode != SUM_AS_GIVEN)
        begin
            good = true_checksum(hdr, payload);
            case (mode)
                SUM_GOOD:    hdr.rx_checksum = good;
                SUM_FLIPPED: hdr.rx_checksum = good ^ (16'h0001 << $urandom_range(0, 15));
                default:     hdr.rx_checksum = 16'($urandom);
            endcase
        end
        put_beat(hdr);
        items_sent++;
        foreach (payload[i])
        begin
            put_data(payload[i]);
            items_sent++;
        end
    endtask

    // Sample both channels at the edge; every drive is nonblocking
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (item_valid && item_ready)
                    tracker.note_item(item);
                if (result_valid && result_ready)
                    tracker.check_result(result);
            end
        end
    end

    initial
    begin
        ready_mode_t mode;
        int          mode_left;
        int          holds_done;
        mode       = RDY_ALWAYS;
        mode_left  = 0;
        holds_done = 0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if ((holds_done == 0 && tracker.checked >= 15) ||
                (holds_done == 1 && tracker.checked >= 60))
            begin
                // hold off long enough for the block to back up its input
                result_ready <= 1'b0;
                repeat (HoldCycles) @(posedge clk);
                holds_done++;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = ready_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (mode)
                    RDY_ALWAYS: result_ready <= 1'b1;
                    RDY_COIN:   result_ready <= ($urandom_range(0, 1) == 1);
                    RDY_SPARSE: result_ready <= ($urandom_range(0, 3) == 0);
                    default:    result_ready <= ~result_ready;
                endcase
                @(posedge clk);
            end
        end
    end

    initial
    begin
        while (cycles < CycleLimit)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        item_t     hdr;
        bytes_t    payload;
        int        pick;
        int        n;
        sum_mode_t mode;

        tracker = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: stray byte, empty payloads, odd and even lengths, extremes
        put_data(8'hA5);

        hdr = '0;
        payload = {};
        put_segment(hdr, payload, SUM_GOOD);

        hdr = random_header();
        hdr.conn_id   = 32'hFFFF_FFFF;
        hdr.src_ip    = 32'hFFFF_FFFF;
        hdr.src_port  = 16'hFFFF;
        hdr.hdr_flags = 16'hFFFF;
        hdr.data_len  = 16'd0;
        put_segment(hdr, payload, SUM_FLIPPED);

        hdr.data_len = 16'd1;
        payload = {8'hFF};
        put_segment(hdr, payload, SUM_GOOD);

        hdr = '0;
        hdr.data_len = 16'd2;
        payload = {8'hFF, 8'hFF};
        put_segment(hdr, payload, SUM_GOOD);

        hdr = random_header();
        hdr.data_len = 16'd3;
        payload = {8'h01, 8'h80, 8'hFE};
        put_segment(hdr, payload, SUM_FLIPPED);

        // Abandon a maximum-length segment with a fresh header
        hdr = random_header();
        hdr.data_len = 16'hFFFF;
        payload = {8'h00, 8'hFF};
        put_segment(hdr, payload, SUM_AS_GIVEN);

        hdr = random_header();
        hdr.data_len = 16'd1;
        payload = {8'h7F};
        put_segment(hdr, payload, SUM_GOOD);

        put_data(8'h5A);
        put_data(8'h00);

        hdr = random_header();
        hdr.conn_id     = 32'hFFFF_FFFF;
        hdr.src_ip      = 32'hFFFF_FFFF;
        hdr.src_port    = 16'hFFFF;
        hdr.hdr_flags   = 16'hFFFF;
        hdr.data_len    = 16'hFFFF;
        hdr.rx_checksum = 16'hFFFF;
        payload = {};
        put_segment(hdr, payload, SUM_AS_GIVEN);

        hdr = random_header();
        hdr.data_len = 16'd5;
        payload = {8'h12, 8'h34, 8'h56, 8'h78, 8'h9A};
        put_segment(hdr, payload, SUM_GOOD);

        // Random: mostly complete segments, some cut short, stray bytes between
        items_sent = 0;
        while (items_sent < RandomItems)
        begin
            pick = $urandom_range(0, 99);
            hdr  = random_header();
            payload.delete();
            if (pick < 20)
            begin
                hdr.data_len = 16'($urandom_range(1, 65535));
                n = $urandom_range(0, 6);
                if (n >= int'(hdr.data_len))
                    n = int'(hdr.data_len) - 1;
                repeat (n) payload.push_back(8'($urandom_range(0, 255)));
                put_segment(hdr, payload, SUM_AS_GIVEN);
            end
            else
            begin
                hdr.data_len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(13, 80))
                                                           : 16'($urandom_range(0, 12));
                repeat (hdr.data_len) payload.push_back(8'($urandom_range(0, 255)));
                n = $urandom_range(0, 3);
                mode = (n < 2) ? SUM_GOOD : ((n == 2) ? SUM_FLIPPED : SUM_RANDOM);
                put_segment(hdr, payload, mode);
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3)) put_data(8'($urandom_range(0, 255)));
            end
        end

        item_valid <= 1'b0;
        while (tracker.expected_results.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        if (tracker.errors == 0 && tracker.expected_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
